// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Every check samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk_i.
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition is never true.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_AT(lbl, !(cond), msg)

`endif

// File: rtl/fpalu_pkg.sv
// ----------------------------------------------------------------------------
// fpalu_pkg
// Shared types, constants and helper functions for the Q24.8 fixed-point ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package fpalu_pkg;

  // Number format and datapath sizes.
  localparam int unsigned FRAC_BITS   = 8;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned QUOT_W      = DATA_W + FRAC_BITS;
  localparam int unsigned REM_W       = DATA_W + 1;
  localparam int unsigned PROD_W      = 2 * DATA_W;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  localparam logic signed [63:0] I32_MAX_64  = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] I32_MIN_64  = 64'shFFFF_FFFF_8000_0000;
  localparam logic        [63:0] FRAC_MASK64 = (64'd1 << FRAC_BITS) - 64'd1;
  localparam logic        [63:0] HALF_LSB64  = 64'd1 << (FRAC_BITS - 1);
  localparam logic        [31:0] I32_MAX     = 32'h7FFF_FFFF;
  localparam logic        [31:0] I32_MIN     = 32'h8000_0000;

  // Operation codes.
  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_MIN      = 4'd4,
    OP_MAX      = 4'd5,
    OP_INC      = 4'd6,
    OP_DEC      = 4'd7,
    OP_TO_INT   = 4'd8,
    OP_FROM_INT = 4'd9
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_e;

  // How the back end finishes a transaction.
  typedef enum logic [1:0] {
    KIND_SIMPLE = 2'd0,
    KIND_MUL    = 2'd1,
    KIND_DIV    = 2'd2
  } kind_e;

  typedef struct packed {
    logic less;
    logic equal;
    logic greater;
  } flags_t;

  // Classified transaction handed from the front end to the back end.
  typedef struct packed {
    kind_e       kind;
    logic [31:0] result;
    status_e     status;
    flags_t      flags;
    logic        neg;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
  } work_t;

  typedef struct packed {
    logic [31:0] value;
    logic        ovf;
  } sat_t;

  // Saturates a wide signed value to the signed 32-bit range.
  function automatic sat_t sat_to_32(input logic signed [63:0] v);
    sat_t r;
    r.value = v[31:0];
    r.ovf   = 1'b0;
    if (v > I32_MAX_64) begin
      r.value = I32_MAX;
      r.ovf   = 1'b1;
    end else if (v < I32_MIN_64) begin
      r.value = I32_MIN;
      r.ovf   = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/fpalu_front.sv
// ----------------------------------------------------------------------------
// fpalu_front
// Accepts transactions, computes the compare flags and the results of the simple
// operations, and prepares magnitudes for the multiply and divide units.
// ----------------------------------------------------------------------------
`default_nettype none

module fpalu_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [3:0]          req_type_i,
  input  logic signed [31:0]  operand_a_i,
  input  logic signed [31:0]  operand_b_i,
  output logic                push_o,
  input  logic                full_i,
  output fpalu_pkg::work_t    work_o
);
  import fpalu_pkg::*;

  logic             f_valid_q, f_valid_d;
  work_t            f_data_q, f_data_d;
  logic             accept;
  logic signed [63:0] a64, b64, sum64, diff64, inc64, dec64, fix64, int64v;
  sat_t             sat_add, sat_sub, sat_inc, sat_dec, sat_fix;
  op_e              op;

  // The holding register stalls only when the queue cannot take its contents.
  assign in_stall_o = f_valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = f_valid_q && !full_i;
  assign work_o     = f_data_q;
  assign f_valid_d  = accept || (f_valid_q && full_i);

  // Wide sign-extended arithmetic for the simple operations.
  assign op      = op_e'(req_type_i);
  assign a64     = {{32{operand_a_i[31]}}, operand_a_i};
  assign b64     = {{32{operand_b_i[31]}}, operand_b_i};
  assign sum64   = a64 + b64;
  assign diff64  = a64 - b64;
  assign inc64   = a64 + 64'sd1;
  assign dec64   = a64 - 64'sd1;
  assign fix64   = a64 <<< FRAC_BITS;
  assign int64v  = (a64 + (operand_a_i[31] ? $signed(FRAC_MASK64) : 64'sd0)) >>> FRAC_BITS;
  assign sat_add = sat_to_32(sum64);
  assign sat_sub = sat_to_32(diff64);
  assign sat_inc = sat_to_32(inc64);
  assign sat_dec = sat_to_32(dec64);
  assign sat_fix = sat_to_32(fix64);

  // Classification of the incoming transaction.
  always_comb begin
    f_data_d               = '0;
    f_data_d.kind          = KIND_SIMPLE;
    f_data_d.status        = ST_OK;
    f_data_d.flags.less    = operand_a_i < operand_b_i;
    f_data_d.flags.equal   = operand_a_i == operand_b_i;
    f_data_d.flags.greater = operand_a_i > operand_b_i;
    f_data_d.neg           = operand_a_i[31] ^ operand_b_i[31];
    f_data_d.mag_a         = operand_a_i[31] ? 32'(-operand_a_i) : operand_a_i;
    f_data_d.mag_b         = operand_b_i[31] ? 32'(-operand_b_i) : operand_b_i;
    unique case (op)
      OP_ADD: begin
        f_data_d.result = sat_add.value;
        f_data_d.status = sat_add.ovf ? ST_OVERFLOW : ST_OK;
      end
      OP_SUB: begin
        f_data_d.result = sat_sub.value;
        f_data_d.status = sat_sub.ovf ? ST_OVERFLOW : ST_OK;
      end
      OP_MUL: begin
        f_data_d.kind = KIND_MUL;
      end
      OP_DIV: begin
        if (operand_b_i == 32'sd0) begin
          f_data_d.status = ST_DIV_ZERO;
          if (operand_a_i > 32'sd0) begin
            f_data_d.result = I32_MAX;
          end else if (operand_a_i < 32'sd0) begin
            f_data_d.result = I32_MIN;
          end
        end else begin
          f_data_d.kind = KIND_DIV;
        end
      end
      OP_MIN: begin
        f_data_d.result = f_data_d.flags.less ? operand_a_i : operand_b_i;
      end
      OP_MAX: begin
        f_data_d.result = f_data_d.flags.less ? operand_b_i : operand_a_i;
      end
      OP_INC: begin
        f_data_d.result = sat_inc.value;
        f_data_d.status = sat_inc.ovf ? ST_OVERFLOW : ST_OK;
      end
      OP_DEC: begin
        f_data_d.result = sat_dec.value;
        f_data_d.status = sat_dec.ovf ? ST_OVERFLOW : ST_OK;
      end
      OP_TO_INT: begin
        f_data_d.result = int64v[31:0];
      end
      OP_FROM_INT: begin
        f_data_d.result = sat_fix.value;
        f_data_d.status = sat_fix.ovf ? ST_OVERFLOW : ST_OK;
      end
      default: begin
        f_data_d.result = '0;
      end
    endcase
  end

  // Holding register valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  // Holding register payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_data_q <= f_data_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/fpalu_queue.sv
// ----------------------------------------------------------------------------
// fpalu_queue
// Short FIFO that decouples the front end from the back-end pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fpalu_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  fpalu_pkg::work_t  push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output fpalu_pkg::work_t  pop_data_o
);
  import fpalu_pkg::*;

  work_t                    mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QUEUE_PTR_W:0]     count_q, count_d;

  assign full_o     = count_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
  assign empty_o    = count_q == '0;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (QUEUE_PTR_W+1)'(push_i) - (QUEUE_PTR_W+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `ASSERT_NEVER(a_no_overflow, push_i && full_o && !pop_i, "queue pushed while full")
  `ASSERT_NEVER(a_no_underflow, pop_i && empty_o, "queue popped while empty")
  `ASSERT_AT(a_count_bound, count_q <= (QUEUE_PTR_W+1)'(QUEUE_DEPTH), "queue count out of range")

endmodule

`default_nettype wire

// File: rtl/fpalu_back.sv
// ----------------------------------------------------------------------------
// fpalu_back
// Execution pipeline: a multiply stage, one restoring divide step per stage,
// and a final rounding and saturation stage feeding the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fpalu_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  fpalu_pkg::work_t   work_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] result_value_o,
  output logic               a_less_o,
  output logic               a_equal_o,
  output logic               a_greater_o,
  output logic [1:0]         status_o
);
  import fpalu_pkg::*;

  typedef struct packed {
    kind_e              kind;
    logic [31:0]        result;
    status_e            status;
    flags_t             flags;
    logic               neg;
    logic [PROD_W-1:0]  prod;
    logic [REM_W-1:0]   rem;
    logic [QUOT_W-1:0]  quo;
    logic [31:0]        divisor;
  } stage_t;

  localparam int unsigned LAST = QUOT_W;

  stage_t              s_q [LAST+1];
  logic [LAST:0]       v_q;
  stage_t              s0_d;
  logic                adv;
  logic                out_valid_q;
  logic [31:0]         out_value_q, out_value_d;
  flags_t              out_flags_q;
  status_e             out_status_q, out_status_d;
  logic                round_up;
  logic [63:0]         mag;
  logic signed [63:0]  signed_val;
  sat_t                fin_sat;

  // One restoring division step: bring down one dividend bit.
  function automatic stage_t div_step(input stage_t s);
    stage_t           r;
    logic [REM_W-1:0] rem_sh;
    logic             qbit;
    r      = s;
    rem_sh = {s.rem[REM_W-2:0], s.quo[QUOT_W-1]};
    qbit   = rem_sh >= {1'b0, s.divisor};
    r.rem  = qbit ? rem_sh - {1'b0, s.divisor} : rem_sh;
    r.quo  = {s.quo[QUOT_W-2:0], qbit};
    return r;
  endfunction

  // The whole pipeline moves unless a finished result is held by the receiver.
  assign adv   = !(out_valid_q && out_stall_i);
  assign pop_o = adv && !empty_i;

  // Entry stage: multiply magnitudes and set up the divider.
  always_comb begin
    s0_d         = '0;
    s0_d.kind    = work_i.kind;
    s0_d.result  = work_i.result;
    s0_d.status  = work_i.status;
    s0_d.flags   = work_i.flags;
    s0_d.neg     = work_i.neg;
    s0_d.prod    = work_i.mag_a * work_i.mag_b;
    s0_d.rem     = '0;
    s0_d.quo     = {work_i.mag_a, {FRAC_BITS{1'b0}}};
    s0_d.divisor = work_i.mag_b;
  end

  // Final stage: round half away from zero, apply the sign, saturate.
  always_comb begin
    round_up = {s_q[LAST].rem, 1'b0} >= {2'b00, s_q[LAST].divisor};
    if (s_q[LAST].kind == KIND_MUL) begin
      mag = (s_q[LAST].prod + HALF_LSB64) >> FRAC_BITS;
    end else begin
      mag = {{(64-QUOT_W){1'b0}}, s_q[LAST].quo} + {63'd0, round_up};
    end
    signed_val = s_q[LAST].neg ? -$signed(mag) : $signed(mag);
    fin_sat    = sat_to_32(signed_val);
    if (s_q[LAST].kind == KIND_SIMPLE) begin
      out_value_d  = s_q[LAST].result;
      out_status_d = s_q[LAST].status;
    end else begin
      out_value_d  = fin_sat.value;
      out_status_d = fin_sat.ovf ? ST_OVERFLOW : ST_OK;
    end
  end

  // Stage valid bits and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v_q         <= {v_q[LAST-1:0], pop_o};
      out_valid_q <= v_q[LAST];
    end
  end

  // Stage payloads and output payload.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_q[0] <= s0_d;
      for (int k = 1; k <= LAST; k++) begin
        s_q[k] <= div_step(s_q[k-1]);
      end
      out_value_q  <= out_value_d;
      out_status_q <= out_status_d;
      out_flags_q  <= s_q[LAST].flags;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign a_less_o       = out_flags_q.less;
  assign a_equal_o      = out_flags_q.equal;
  assign a_greater_o    = out_flags_q.greater;
  assign status_o       = out_status_q;

  `ASSERT_AT(a_flags_onehot, !out_valid_q || $onehot({a_less_o, a_equal_o, a_greater_o}),
             "compare flags not exactly one")
  `ASSERT_AT(a_rem_bound, !(v_q[LAST] && s_q[LAST].kind == KIND_DIV) ||
             (s_q[LAST].rem < {1'b0, s_q[LAST].divisor}), "divider remainder too large")

endmodule

`default_nettype wire

// File: rtl/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed Q24.8 fixed-point ALU with rounding multiply and divide.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: req_type_i, operand_a_i and operand_b_i form one transaction,
//   taken on a rising edge with in_valid_i high and in_stall_o low.
//   Output channel: one result per transaction, in order, taken on a rising
//   edge with out_valid_o high and out_stall_i low.
//   A result passes, in order, through one front-end register, one queue slot,
//   a multiply stage, one divide step per quotient bit, and the rounding
//   stage into the output register.
//   Throughput is one transaction per cycle while the receiver does not stall;
//   the bit-per-stage divider is fully pipelined, so every operation takes
//   the same path.
//   When the receiver stalls, the execution pipeline freezes and the
//   four-entry queue plus the front-end register keep taking transactions
//   until they fill; then in_stall_o rises.
//   Reset clears all valid state; no result is pending afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_alu (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         req_type_i,
  input  logic signed [31:0] operand_a_i,
  input  logic signed [31:0] operand_b_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] result_value_o,
  output logic               a_less_o,
  output logic               a_equal_o,
  output logic               a_greater_o,
  output logic [1:0]         status_o
);
  import fpalu_pkg::*;

  work_t push_data, pop_data;
  logic  push, full, pop, empty;

  // Front end: accept and classify.
  fpalu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .push_o      (push),
    .full_i      (full),
    .work_o      (push_data)
  );

  // Decoupling queue.
  fpalu_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  // Back end: execute and deliver.
  fpalu_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .work_i         (pop_data),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_value_o (result_value_o),
    .a_less_o       (a_less_o),
    .a_equal_o      (a_equal_o),
    .a_greater_o    (a_greater_o),
    .status_o       (status_o)
  );

endmodule

`default_nettype wire
